### src/fts_pkg.sv
// Shared types and codes for the floppy transfer sequencer.
package fts_pkg;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_OUT  = 4'b1000
  } ctl_state_t;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_MOTOR    = 7'b0000010,
    PH_SEEK     = 7'b0000100,
    PH_SEEKSET  = 7'b0001000,
    PH_IO       = 7'b0010000,
    PH_RECAL    = 7'b0100000,
    PH_RECALSET = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    TAIL_NONE = 2'd0,
    TAIL_SEEK = 2'd1,
    TAIL_XFER = 2'd2
  } tail_t;

  localparam logic [2:0] OP_REQUEST = 3'd0;
  localparam logic [2:0] OP_CMD_DONE = 3'd1;
  localparam logic [2:0] OP_SETTLE = 3'd2;
  localparam logic [2:0] OP_MOTOR_READY = 3'd3;
  localparam logic [2:0] OP_TIMEOUT = 3'd4;

  localparam logic [3:0] ACT_SELECT = 4'd0;
  localparam logic [3:0] ACT_MOTOR_ON = 4'd1;
  localparam logic [3:0] ACT_SEEK = 4'd2;
  localparam logic [3:0] ACT_SETTLE = 4'd3;
  localparam logic [3:0] ACT_READ = 4'd4;
  localparam logic [3:0] ACT_WRITE = 4'd5;
  localparam logic [3:0] ACT_RESET = 4'd6;
  localparam logic [3:0] ACT_RECAL = 4'd7;
  localparam logic [3:0] ACT_DONE = 4'd8;
  localparam logic [3:0] ACT_FAILED = 4'd9;
  localparam logic [3:0] ACT_NO_SPACE = 4'd10;
  localparam logic [3:0] ACT_END_MEDIA = 4'd11;

  localparam logic [2:0] REG_SPT = 3'd0;
  localparam logic [2:0] REG_HEADS = 3'd1;
  localparam logic [2:0] REG_STEPS = 3'd2;
  localparam logic [2:0] REG_DISK = 3'd3;
  localparam logic [2:0] REG_SIZE = 3'd4;
  localparam logic [2:0] REG_GAP = 3'd5;
  localparam logic [2:0] REG_DLEN = 3'd6;
  localparam logic [2:0] REG_RATE = 3'd7;

  localparam logic [7:0] ST0_ERROR_MASK = 8'hF8;
  localparam logic [7:0] ST0_TIMEOUT = 8'hC0;
  localparam logic [8:0] POS_UNKNOWN = 9'h100;
  localparam int unsigned DivSteps = 17;

  typedef struct packed {
    logic [3:0] action;
    logic       drive;
    logic [7:0] cylinder;
    logic       head;
    logic [5:0] sector;
    logic [7:0] residual;
  } result_t;

endpackage

### src/floppy_transfer_sequencer_core.sv
// Top level of the floppy transfer sequencer: request and event sequencing with a serial divider.
//
// Usage: each input transaction on the in_ channel is a request or an event
// (command done, settle timer, motor ready, I/O timeout). The block answers
// with zero to two result transactions on the out_ channel, the final one
// flagged by out_last; an input that causes nothing gives no result.
// The block is not ready for a new input until every result of the previous
// one has been taken. After an input is accepted, a shared restoring divider
// splits the block number into cylinder, head and sector, and a decision
// state then works out the results. The results are offered in order, each
// held until the receiver takes it, and the block is ready again in the cycle
// after the last result is taken.
// A stalled receiver simply holds the current result; nothing is lost.
// The cfg_ channel is always ready; the user writes it while the block is idle (not enforced).
// After reset all drives have unknown head positions and motors off, and the
// geometry registers hold the values of a 1.44 MB medium.
module floppy_transfer_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic        in_drive,
  input  logic        in_is_read,
  input  logic [15:0] in_start_block,
  input  logic [7:0]  in_block_count,
  input  logic [7:0]  in_status0,
  input  logic [7:0]  in_cylinder_reported,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_action,
  output logic        out_target_drive,
  output logic [7:0]  out_cylinder,
  output logic        out_head,
  output logic [5:0]  out_sector,
  output logic [7:0]  out_residual,
  output logic        out_last
);

  fts_pkg::ctl_state_t state_r, state_nxt;
  fts_pkg::phase_t     phase_r, phase_nxt;

  logic [5:0]  spt_r;
  logic [1:0]  heads_r;
  logic [1:0]  steps_r;
  logic [15:0] disk_r;
  logic [2:0]  size_r;
  logic [7:0]  gap_r;
  logic [7:0]  dlen_r;
  logic [1:0]  rate_r;

  logic [2:0]  op_r;
  logic        drv_r, rd_r;
  logic [15:0] start_r;
  logic [7:0]  count_r, st0_r, rep_r;

  logic [3:0]  retry_r, retry_nxt;
  logic [8:0]  hp_r [2];
  logic [8:0]  hp_nxt [2];
  logic [1:0]  mon_r, mon_nxt, mpend_r, mpend_nxt;
  logic        req_drv_r, req_drv_nxt, req_rd_r, req_rd_nxt;
  logic [15:0] req_start_r, req_start_nxt;
  logic [7:0]  req_count_r, req_count_nxt, done_r, done_nxt, lstat_r, lstat_nxt;

  logic [16:0] quo_r;
  logic [7:0]  rem_r;
  logic [4:0]  cnt_r;

  fts_pkg::result_t buf_r [2];
  fts_pkg::result_t res [2];
  logic [1:0]  nres_r, nres;
  logic        idx_r;

  logic [5:0]  spt_eff;
  logic [1:0]  heads_eff;
  logic [6:0]  divisor;
  logic [7:0]  trial;
  logic        trial_ge;
  logic [16:0] blk;
  logic        in_acc, out_acc;

  logic [7:0]  cyl, phys;
  logic        hd;
  logic [5:0]  sec;
  logic [9:0]  phys_full;
  logic        dsel, known, fault_en;
  logic [8:0]  hp_cur;
  logic [3:0]  r;
  fts_pkg::tail_t tail;

  function automatic fts_pkg::result_t mk(input logic [3:0] a, input logic d,
                                          input logic [7:0] c, input logic h,
                                          input logic [5:0] s, input logic [7:0] rs);
    fts_pkg::result_t t;
    t.action = a;
    t.drive = d;
    t.cylinder = c;
    t.head = h;
    t.sector = s;
    t.residual = rs;
    return t;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == fts_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = (state_r == fts_pkg::ST_OUT);
  assign out_acc   = out_valid && out_ready;

  assign out_action       = buf_r[idx_r].action;
  assign out_target_drive = buf_r[idx_r].drive;
  assign out_cylinder     = buf_r[idx_r].cylinder;
  assign out_head         = buf_r[idx_r].head;
  assign out_sector       = buf_r[idx_r].sector;
  assign out_residual     = buf_r[idx_r].residual;
  assign out_last         = ({1'b0, idx_r} == (nres_r - 2'd1));

  assign spt_eff   = (spt_r == 6'd0) ? 6'd1 : spt_r;
  assign heads_eff = (heads_r == 2'd0) ? 2'd1 : ((heads_r == 2'd3) ? 2'd2 : heads_r);
  assign divisor   = (heads_eff == 2'd2) ? {spt_eff, 1'b0} : {1'b0, spt_eff};
  assign trial     = {rem_r[6:0], quo_r[16]};
  assign trial_ge  = (trial >= {1'b0, divisor});

  always_comb begin
    if (in_opcode == fts_pkg::OP_REQUEST && phase_r == fts_pkg::PH_IDLE) begin
      blk = {1'b0, in_start_block};
    end else begin
      blk = {1'b0, req_start_r} + {9'b0, done_r}
          + {16'b0, (in_opcode == fts_pkg::OP_CMD_DONE && phase_r == fts_pkg::PH_IO &&
                     (in_status0 & fts_pkg::ST0_ERROR_MASK) == 8'h00)};
    end
  end

  assign cyl       = quo_r[7:0];
  assign hd        = (rem_r[6:0] >= {1'b0, spt_eff});
  assign sec       = (hd ? (rem_r[5:0] - spt_eff) : rem_r[5:0]) + 6'd1;
  assign phys_full = {2'b0, cyl} * {8'b0, steps_r};
  assign phys      = phys_full[7:0];

  always_comb begin
    phase_nxt = phase_r;
    retry_nxt = retry_r;
    hp_nxt = hp_r;
    mon_nxt = mon_r;
    mpend_nxt = mpend_r;
    req_drv_nxt = req_drv_r;
    req_rd_nxt = req_rd_r;
    req_start_nxt = req_start_r;
    req_count_nxt = req_count_r;
    done_nxt = done_r;
    lstat_nxt = lstat_r;
    res[0] = '0;
    res[1] = '0;
    nres = 2'd0;
    tail = fts_pkg::TAIL_NONE;
    fault_en = 1'b0;
    dsel = req_drv_r;
    hp_cur = hp_r[req_drv_r];
    known = 1'b0;
    r = retry_r;
    case (op_r)
      fts_pkg::OP_REQUEST: begin
        if (phase_r == fts_pkg::PH_IDLE) begin
          if ({1'b0, start_r} + {9'b0, count_r} > {1'b0, disk_r}) begin
            res[0] = mk((start_r == disk_r) ? fts_pkg::ACT_END_MEDIA : fts_pkg::ACT_NO_SPACE,
                        drv_r, 8'd0, 1'b0, 6'd0, count_r);
            nres = 2'd1;
          end else if (count_r == 8'd0) begin
            res[0] = mk(fts_pkg::ACT_DONE, drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
            nres = 2'd1;
          end else begin
            req_drv_nxt = drv_r;
            req_rd_nxt = rd_r;
            req_start_nxt = start_r;
            req_count_nxt = count_r;
            retry_nxt = 4'd0;
            done_nxt = 8'd0;
            dsel = drv_r;
            hp_cur = hp_r[drv_r];
            if (mpend_r[drv_r]) begin
              phase_nxt = fts_pkg::PH_MOTOR;
            end else if (!mon_r[drv_r]) begin
              mon_nxt[drv_r] = 1'b1;
              mpend_nxt[drv_r] = 1'b1;
              res[0] = mk(fts_pkg::ACT_MOTOR_ON, drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
              nres = 2'd1;
              phase_nxt = fts_pkg::PH_MOTOR;
            end else begin
              res[0] = mk(fts_pkg::ACT_SELECT, drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
              nres = 2'd1;
              tail = fts_pkg::TAIL_SEEK;
            end
          end
        end
      end
      fts_pkg::OP_CMD_DONE: begin
        if (phase_r == fts_pkg::PH_SEEK || phase_r == fts_pkg::PH_RECAL) begin
          res[0] = mk(fts_pkg::ACT_SETTLE, req_drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
          nres = 2'd1;
          phase_nxt = (phase_r == fts_pkg::PH_SEEK) ? fts_pkg::PH_SEEKSET
                                                    : fts_pkg::PH_RECALSET;
        end else if (phase_r == fts_pkg::PH_IO) begin
          lstat_nxt = st0_r;
          if ((st0_r & fts_pkg::ST0_ERROR_MASK) != 8'h00) begin
            fault_en = 1'b1;
          end else begin
            done_nxt = done_r + 8'd1;
            if (done_nxt < req_count_r) begin
              tail = fts_pkg::TAIL_SEEK;
            end else begin
              res[0] = mk(fts_pkg::ACT_DONE, req_drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
              nres = 2'd1;
              phase_nxt = fts_pkg::PH_IDLE;
            end
          end
        end
      end
      fts_pkg::OP_SETTLE: begin
        if (phase_r == fts_pkg::PH_SEEKSET) begin
          if (hp_cur[8] && rep_r != phys) fault_en = 1'b1;
          else tail = fts_pkg::TAIL_XFER;
        end else if (phase_r == fts_pkg::PH_RECALSET) begin
          if (rep_r != 8'd0) begin
            fault_en = 1'b1;
          end else begin
            hp_cur = 9'd0;
            hp_nxt[req_drv_r] = 9'd0;
            tail = fts_pkg::TAIL_SEEK;
          end
        end
      end
      fts_pkg::OP_MOTOR_READY: begin
        mpend_nxt[drv_r] = 1'b0;
        if (phase_r == fts_pkg::PH_MOTOR && drv_r == req_drv_r) tail = fts_pkg::TAIL_SEEK;
      end
      fts_pkg::OP_TIMEOUT: begin
        if (phase_r == fts_pkg::PH_IO) begin
          lstat_nxt = fts_pkg::ST0_TIMEOUT;
          if (retry_r >= 4'd8) begin
            res[0] = mk(fts_pkg::ACT_FAILED, req_drv_r, 8'd0, 1'b0, 6'd0,
                        req_count_r - done_r);
            nres = 2'd1;
            phase_nxt = fts_pkg::PH_IDLE;
          end else begin
            r = (retry_r + 4'd1 < 4'd6) ? 4'd6 : retry_r + 4'd1;
            retry_nxt = r;
            fault_en = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (fault_en) begin
      known = !hp_cur[8] || (rep_r == phys);
      if ((r <= 4'd2 || r == 4'd7) && known) begin
        retry_nxt = r + 4'd1;
        tail = fts_pkg::TAIL_XFER;
      end else if (r <= 4'd5 && !(r == 4'd7)) begin
        retry_nxt = (r <= 4'd2) ? 4'd4 : r + 4'd1;
        res[0] = mk(fts_pkg::ACT_RECAL, req_drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
        nres = 2'd1;
        phase_nxt = fts_pkg::PH_RECAL;
      end else if (r == 4'd6) begin
        retry_nxt = 4'd8;
        res[0] = mk(fts_pkg::ACT_RESET, req_drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
        res[1] = mk(fts_pkg::ACT_RECAL, req_drv_r, 8'd0, 1'b0, 6'd0, 8'd0);
        nres = 2'd2;
        phase_nxt = fts_pkg::PH_RECAL;
      end else begin
        if (r == 4'd7) retry_nxt = 4'd8;
        res[0] = mk(fts_pkg::ACT_FAILED, req_drv_r, 8'd0, 1'b0, 6'd0,
                    req_count_r - done_r);
        nres = 2'd1;
        phase_nxt = fts_pkg::PH_IDLE;
      end
    end

    if (tail == fts_pkg::TAIL_SEEK && hp_cur == {1'b0, cyl}) tail = fts_pkg::TAIL_XFER;
    if (tail == fts_pkg::TAIL_SEEK) begin
      res[nres[0]] = mk(fts_pkg::ACT_SEEK, dsel, phys, 1'b0, 6'd0, 8'd0);
      nres = nres + 2'd1;
      hp_nxt[dsel] = fts_pkg::POS_UNKNOWN;
      phase_nxt = fts_pkg::PH_SEEK;
    end else if (tail == fts_pkg::TAIL_XFER) begin
      res[nres[0]] = mk((dsel == drv_r && op_r == fts_pkg::OP_REQUEST) ?
                        (rd_r ? fts_pkg::ACT_READ : fts_pkg::ACT_WRITE) :
                        (req_rd_r ? fts_pkg::ACT_READ : fts_pkg::ACT_WRITE),
                        dsel, cyl, hd, sec, 8'd0);
      nres = nres + 2'd1;
      hp_nxt[dsel] = {1'b0, cyl};
      phase_nxt = fts_pkg::PH_IO;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fts_pkg::ST_IDLE: if (in_acc) state_nxt = fts_pkg::ST_DIV;
      fts_pkg::ST_DIV:  if (cnt_r == 5'd1) state_nxt = fts_pkg::ST_EXEC;
      fts_pkg::ST_EXEC: state_nxt = (nres == 2'd0) ? fts_pkg::ST_IDLE : fts_pkg::ST_OUT;
      fts_pkg::ST_OUT:  if (out_acc && out_last) state_nxt = fts_pkg::ST_IDLE;
      default:          state_nxt = fts_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fts_pkg::ST_IDLE;
      phase_r <= fts_pkg::PH_IDLE;
      retry_r <= 4'd0;
      hp_r[0] <= fts_pkg::POS_UNKNOWN;
      hp_r[1] <= fts_pkg::POS_UNKNOWN;
      mon_r <= 2'b00;
      mpend_r <= 2'b00;
      req_drv_r <= 1'b0;
      req_rd_r <= 1'b0;
      req_start_r <= 16'd0;
      req_count_r <= 8'd0;
      done_r <= 8'd0;
      lstat_r <= 8'd0;
      spt_r <= 6'd18;
      heads_r <= 2'd2;
      steps_r <= 2'd1;
      disk_r <= 16'd2880;
      size_r <= 3'd2;
      gap_r <= 8'd27;
      dlen_r <= 8'd255;
      rate_r <= 2'd0;
      cnt_r <= 5'd0;
      nres_r <= 2'd0;
      idx_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fts_pkg::REG_SPT:   spt_r <= cfg_data[5:0];
          fts_pkg::REG_HEADS: heads_r <= cfg_data[1:0];
          fts_pkg::REG_STEPS: steps_r <= cfg_data[1:0];
          fts_pkg::REG_DISK:  disk_r <= cfg_data;
          fts_pkg::REG_SIZE:  size_r <= cfg_data[2:0];
          fts_pkg::REG_GAP:   gap_r <= cfg_data[7:0];
          fts_pkg::REG_DLEN:  dlen_r <= cfg_data[7:0];
          fts_pkg::REG_RATE:  rate_r <= cfg_data[1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        cnt_r <= 5'(fts_pkg::DivSteps);
      end else if (state_r == fts_pkg::ST_DIV) begin
        cnt_r <= cnt_r - 5'd1;
      end
      if (state_r == fts_pkg::ST_EXEC) begin
        phase_r <= phase_nxt;
        retry_r <= retry_nxt;
        hp_r <= hp_nxt;
        mon_r <= mon_nxt;
        mpend_r <= mpend_nxt;
        req_drv_r <= req_drv_nxt;
        req_rd_r <= req_rd_nxt;
        req_start_r <= req_start_nxt;
        req_count_r <= req_count_nxt;
        done_r <= done_nxt;
        lstat_r <= lstat_nxt;
        nres_r <= nres;
        idx_r <= 1'b0;
      end
      if (out_acc && !out_last) idx_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= in_opcode;
      drv_r <= in_drive;
      rd_r <= in_is_read;
      start_r <= in_start_block;
      count_r <= in_block_count;
      st0_r <= in_status0;
      rep_r <= in_cylinder_reported;
      quo_r <= blk;
      rem_r <= 8'd0;
    end else if (state_r == fts_pkg::ST_DIV) begin
      quo_r <= {quo_r[15:0], trial_ge};
      rem_r <= trial_ge ? (trial - {1'b0, divisor}) : trial;
    end
    if (state_r == fts_pkg::ST_EXEC) begin
      buf_r <= res;
    end
  end

endmodule
